### hdl/brra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brra_pkg - shared definitions for the round-robin bus arbiter
// Agent count, field widths, register indexes and inter-module structs.
// ----------------------------------------------------------------------------
package brra_pkg;

	// Agent count; kept a power of two so the random start is a mask.
	localparam int NUM_AGENTS = 16;
	localparam int AGENT_W    = $clog2(NUM_AGENTS);

	// Widths of the per-agent activity vectors, the random draw and the linger period
	localparam int LINE_W     = 16;
	localparam int DRAW_W     = 31;
	localparam int LINGER_W   = 16;

	// Stream word widths (packed fields rounded up to whole bytes)
	localparam int IN_FIELDS_W  = 3 * LINE_W + DRAW_W;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 3 + 2 * AGENT_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	// Remainder unit: dividend padded to whole steps, DIV_STEP bits per cycle
	localparam int DIV_STEP  = 4;
	localparam int DIV_PAD_W = ((DRAW_W + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
	localparam int DIV_ITERS = DIV_PAD_W / DIV_STEP;
	localparam int DIV_CNT_W = (DIV_ITERS > 1) ? $clog2(DIV_ITERS) : 1;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PARK_LAST     = 1'b0,
		REG_LINGER_PERIOD = 1'b1
	} cfg_reg_t;

	// Round-robin pick result
	typedef struct packed {
		logic               found;
		logic [AGENT_W-1:0] agent;
	} pick_t;

	// Remainder unit status
	typedef struct packed {
		logic busy;
		logic done;
		logic zero;
	} div_status_t;

endpackage

### hdl/brra_rr_pick.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brra_rr_pick - round-robin requester select
// Finds the first requesting agent after the start agent, wrapping around.
// ----------------------------------------------------------------------------
module brra_rr_pick (
	input  logic [brra_pkg::NUM_AGENTS-1:0] req,
	input  logic [brra_pkg::AGENT_W-1:0]    start,
	output brra_pkg::pick_t                 pick
);
	import brra_pkg::*;

	always_comb begin
		logic [AGENT_W:0] sum;
		logic [AGENT_W:0] wrapped;
		pick = '0;
		// walk farthest first so the nearest requester wins
		for (int k = NUM_AGENTS; k >= 1; k--) begin
			sum = {1'b0, start} + (AGENT_W+1)'(k);
			wrapped = (sum >= (AGENT_W+1)'(NUM_AGENTS)) ?
				sum - (AGENT_W+1)'(NUM_AGENTS) : sum;
			if (req[wrapped[AGENT_W-1:0]]) begin
				pick.found = 1'b1;
				pick.agent = wrapped[AGENT_W-1:0];
			end
		end
	end

endmodule

### hdl/brra_mod_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brra_mod_unit - iterative remainder of the random draw by linger period
// Restoring division, DIV_STEP quotient bits per cycle; flags a zero remainder.
// ----------------------------------------------------------------------------
module brra_mod_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [brra_pkg::DRAW_W-1:0]   dividend,
	input  logic [brra_pkg::LINGER_W-1:0] divisor,
	output brra_pkg::div_status_t         status
);
	import brra_pkg::*;

	logic [DIV_PAD_W-1:0] dvd_q;
	logic [LINGER_W-1:0]  rem_q;
	logic [LINGER_W-1:0]  dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIV_PAD_W-1:0] dvd_nx;
	logic [LINGER_W-1:0]  rem_nx;

	always_comb begin
		logic [LINGER_W:0] trial;
		dvd_nx = dvd_q;
		rem_nx = rem_q;
		for (int s = 0; s < DIV_STEP; s++) begin
			trial  = {rem_nx, dvd_nx[DIV_PAD_W-1]};
			dvd_nx = {dvd_nx[DIV_PAD_W-2:0], 1'b0};
			if (trial >= {1'b0, dsr_q})
				trial = trial - {1'b0, dsr_q};
			rem_nx = trial[LINGER_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DIV_ITERS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= DIV_PAD_W'(dividend);
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= dvd_nx;
			rem_q <= rem_nx;
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign status.zero = (rem_q == '0);

endmodule

### hdl/bus_round_robin_arbiter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bus_round_robin_arbiter_core - round-robin bus arbiter with owner tracking
// Per bus clock word: update the bus owner, then arbitrate the grant.
// ----------------------------------------------------------------------------
// Flow: a word is taken in S_IDLE and its result word registered in S_OUT once
//   the output register is free; an idle grant checked for recall first waits
//   in S_DIV on the remainder unit (4 quotient bits a cycle). s_tready is high
//   only in S_IDLE, so a new word is not taken until the last one is through.
// Reset: arst_n clears grant and owner to none, park_last to 0 and
//   linger_period to 16; output channel empty.
// ----------------------------------------------------------------------------
module bus_round_robin_arbiter_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [brra_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [brra_pkg::LINGER_W-1:0]   cfg_data,
	// input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// s_tdata from bit 0: request_active[15:0], frame_active[15:0],
	//   ready_active[15:0], random_draw[30:0], zero pad
	input  logic [brra_pkg::IN_DATA_W-1:0]  s_tdata,
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// m_tdata from bit 0: grant_valid, grant_agent[3:0], owner_valid,
	//   owner_agent[3:0], grant_changed, zero pad
	output logic [brra_pkg::OUT_DATA_W-1:0] m_tdata
);
	import brra_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_OUT
	} state_t;

	// input word fields
	logic [LINE_W-1:0] request_active;
	logic [LINE_W-1:0] frame_active;
	logic [LINE_W-1:0] ready_active;
	logic [DRAW_W-1:0] random_draw;

	assign request_active = s_tdata[LINE_W-1:0];
	assign frame_active   = s_tdata[2*LINE_W-1:LINE_W];
	assign ready_active   = s_tdata[3*LINE_W-1:2*LINE_W];
	assign random_draw    = s_tdata[3*LINE_W+DRAW_W-1:3*LINE_W];

	// registers
	state_t               state_q;
	logic                 park_last_q;
	logic [LINGER_W-1:0]  linger_q;
	logic                 grant_held_q;
	logic [AGENT_W-1:0]   grant_idx_q;
	logic                 owner_held_q;
	logic [AGENT_W-1:0]   owner_idx_q;
	logic                 changed_q;
	logic                 out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic accept;
	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	// agent line lookup: agents without an input bit read as idle
	function automatic logic agent_bit(logic [LINE_W-1:0] v, logic [AGENT_W-1:0] i);
		logic b;
		b = 1'b0;
		for (int k = 0; k < LINE_W; k++)
			if (k < NUM_AGENTS && i == AGENT_W'(k))
				b = v[k];
		return b;
	endfunction

	// request vector over the agents
	logic [NUM_AGENTS-1:0] req_vec;
	always_comb begin
		req_vec = '0;
		for (int k = 0; k < NUM_AGENTS; k++)
			if (k < LINE_W)
				req_vec[k] = request_active[k];
	end

	// owner update from last grant and this clock's FRAME / IRDY
	logic               owner_held_n;
	logic [AGENT_W-1:0] owner_idx_n;
	logic               own_busy;
	assign own_busy = agent_bit(frame_active, owner_idx_q) ||
		agent_bit(ready_active, owner_idx_q);

	always_comb begin
		owner_held_n = owner_held_q;
		owner_idx_n  = owner_idx_q;
		if (!owner_held_q) begin
			if (grant_held_q && agent_bit(frame_active, grant_idx_q)) begin
				owner_held_n = 1'b1;
				owner_idx_n  = grant_idx_q;
			end
		end else if (grant_held_q) begin
			// other owner hands over once its transaction is done
			if (owner_idx_q != grant_idx_q && !own_busy)
				owner_idx_n = grant_idx_q;
		end else if (!own_busy) begin
			owner_held_n = 1'b0;
			owner_idx_n  = '0;
		end
	end

	// round-robin pick; with no holder start at a random agent
	pick_t              pick;
	logic [AGENT_W-1:0] pick_start;
	assign pick_start = grant_held_q ? grant_idx_q : random_draw[AGENT_W-1:0];

	brra_rr_pick u_pick (
		.req   (req_vec),
		.start (pick_start),
		.pick  (pick)
	);

	logic any_req;
	logic holder_req;
	logic recall_chk;
	assign any_req    = |req_vec;
	assign holder_req = grant_held_q && req_vec[grant_idx_q];
	// idle grant may be recalled only while someone owns the bus
	assign recall_chk = !any_req && owner_held_n && grant_held_q &&
		!park_last_q && (linger_q != '0);

	// remainder unit for the recall test
	div_status_t div_st;
	logic        div_start;
	assign div_start = accept && recall_chk;

	brra_mod_unit u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (random_draw),
		.divisor  (linger_q),
		.status   (div_st)
	);

	// result word from the current state
	logic [OUT_FIELDS_W-1:0] out_fields;
	assign out_fields = {changed_q,
		owner_held_q ? owner_idx_q : AGENT_W'(0), owner_held_q,
		grant_held_q ? grant_idx_q : AGENT_W'(0), grant_held_q};

	logic out_free;
	assign out_free = !out_valid_q || m_tready;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			park_last_q <= 1'b0;
			linger_q    <= LINGER_W'(16);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_PARK_LAST:     park_last_q <= cfg_data[0];
				REG_LINGER_PERIOD: linger_q    <= cfg_data;
				default:           ;
			endcase
		end
	end

	// sequencer, arbiter state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			grant_held_q <= 1'b0;
			grant_idx_q  <= '0;
			owner_held_q <= 1'b0;
			owner_idx_q  <= '0;
			changed_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && m_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						owner_held_q <= owner_held_n;
						owner_idx_q  <= owner_idx_n;
						changed_q    <= any_req && !holder_req && pick.found;
						if (any_req && !holder_req && pick.found) begin
							grant_held_q <= 1'b1;
							grant_idx_q  <= pick.agent;
						end
						state_q <= recall_chk ? S_DIV : S_OUT;
					end
				end
				S_DIV: begin
					if (div_st.done && !div_st.busy) begin
						if (div_st.zero) begin
							grant_held_q <= 1'b0;
							grant_idx_q  <= '0;
							changed_q    <= 1'b1;
						end
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free)
			out_data_q <= OUT_DATA_W'(out_fields);
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

### bench/arbiter_grant_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arbiter_grant_checker - grant/owner predictor and result comparator
// Watches the config, input and result channels of the arbiter core, keeps
// its own copy of grant, owner and registers, and compares each result word.
// ----------------------------------------------------------------------------
module arbiter_grant_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [brra_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [brra_pkg::LINGER_W-1:0]   cfg_data,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [brra_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [brra_pkg::OUT_DATA_W-1:0] m_tdata,
	output int                              errors,
	output int                              pending
);
	import brra_pkg::*;

	typedef struct packed {
		logic               grant_valid;
		logic [AGENT_W-1:0] grant_agent;
		logic               owner_valid;
		logic [AGENT_W-1:0] owner_agent;
		logic               grant_changed;
	} arb_word_t;

	arb_word_t grant_words_q[$];

	logic                park_on;
	logic [LINGER_W-1:0] linger_cfg;
	logic                grant_on;
	logic [AGENT_W-1:0]  grant_at;
	logic                owner_on;
	logic [AGENT_W-1:0]  owner_at;

	// owner update first, then arbitration on this word's requests
	task automatic next_grant_owner(input logic [LINE_W-1:0] req,
			input logic [LINE_W-1:0] frm, input logic [LINE_W-1:0] rdy,
			input logic [DRAW_W-1:0] draw, output arb_word_t w);
		logic [AGENT_W-1:0] start;
		logic [AGENT_W-1:0] idx;
		logic               moved;
		logic               found;
		if (!owner_on) begin
			if (grant_on && frm[grant_at]) begin
				owner_on = 1'b1;
				owner_at = grant_at;
			end
		end else if (grant_on) begin
			if (owner_at != grant_at && !frm[owner_at] && !rdy[owner_at])
				owner_at = grant_at;
		end else if (!frm[owner_at] && !rdy[owner_at]) begin
			owner_on = 1'b0;
			owner_at = '0;
		end

		moved = 1'b0;
		if (req == '0) begin
			if (owner_on && grant_on && !park_on && linger_cfg != '0 &&
					(draw % linger_cfg) == 0) begin
				grant_on = 1'b0;
				grant_at = '0;
				moved    = 1'b1;
			end
		end else if (!(grant_on && req[grant_at])) begin
			start = grant_on ? grant_at : AGENT_W'(draw % NUM_AGENTS);
			found = 1'b0;
			for (int k = 1; k <= NUM_AGENTS; k++) begin
				idx = start + AGENT_W'(k);
				if (!found && req[idx]) begin
					found    = 1'b1;
					grant_on = 1'b1;
					grant_at = idx;
					moved    = 1'b1;
				end
			end
		end

		w.grant_valid   = grant_on;
		w.grant_agent   = grant_on ? grant_at : '0;
		w.owner_valid   = owner_on;
		w.owner_agent   = owner_on ? owner_at : '0;
		w.grant_changed = moved;
	endtask

	function automatic int field_diff(input string name, input logic [3:0] want,
			input logic [3:0] got);
		if (want === got)
			return 0;
		$display("%0t: %s expected %0h got %0h", $time, name, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		arb_word_t want;
		if (!arst_n) begin
			park_on    = 1'b0;
			linger_cfg = LINGER_W'(16);
			grant_on   = 1'b0;
			grant_at   = '0;
			owner_on   = 1'b0;
			owner_at   = '0;
			errors     = 0;
			pending    = 0;
			grant_words_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_PARK_LAST:     park_on = cfg_data[0];
					REG_LINGER_PERIOD: linger_cfg = cfg_data;
					default: ;
				endcase
			end
			// result compared before this edge's input is predicted
			if (m_tvalid && m_tready) begin
				if (grant_words_q.size() == 0) begin
					$display("%0t: result word %0h with none expected", $time, m_tdata);
					errors++;
				end else begin
					want = grant_words_q.pop_front();
					errors += field_diff("grant_valid", 4'(want.grant_valid), 4'(m_tdata[0]));
					errors += field_diff("grant_agent", want.grant_agent, m_tdata[4:1]);
					errors += field_diff("owner_valid", 4'(want.owner_valid), 4'(m_tdata[5]));
					errors += field_diff("owner_agent", want.owner_agent, m_tdata[9:6]);
					errors += field_diff("grant_changed", 4'(want.grant_changed),
						4'(m_tdata[10]));
				end
			end
			if (s_tvalid && s_tready) begin
				next_grant_owner(s_tdata[LINE_W-1:0], s_tdata[2*LINE_W-1:LINE_W],
					s_tdata[3*LINE_W-1:2*LINE_W],
					s_tdata[3*LINE_W+DRAW_W-1:3*LINE_W], want);
				grant_words_q.push_back(want);
			end
			pending = grant_words_q.size();
		end
	end

endmodule

### bench/bus_round_robin_arbiter_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bus_round_robin_arbiter_core_test - testbench for the round-robin arbiter
// Directed words after reset, then register settings phases with biased
// random bus activity; a checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module bus_round_robin_arbiter_core_test;
	import brra_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASES         = 8;
	localparam int PHASE_WORDS    = 56;
	// longest result latency (recall check) plus margin
	localparam int SETTLE_CYCLES  = 16;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [LINGER_W-1:0]   cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	int errors;
	int pending;

	// stimulus-side view of the block used to bias bus activity, plus gap, stall and watchdog counters
	logic [AGENT_W-1:0] seen_grant = '0;
	logic [AGENT_W-1:0] seen_owner = '0;
	int unsigned        linger_now = 16;
	int                 burst_left = 0;
	int                 stall_left = 0;
	int                 calm_left = 0;
	int                 idle_cycles = 0;

	bus_round_robin_arbiter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	arbiter_grant_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// mostly short gaps, a few long ones
	function automatic int random_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50)
			return 0;
		if (p < 85)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// result side: random stalls, with calm stretches where it never stalls
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_tready <= 1'b1;
			if (calm_left > 0)
				calm_left <= calm_left - 1;
			else if ($urandom_range(0, 49) == 0)
				calm_left <= $urandom_range(20, 100);
			else if ($urandom_range(0, 2) == 0)
				stall_left <= random_gap();
		end
	end

	// track grant/owner as reported; m_tdata bits 4:1 grant, 9:6 owner
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			seen_grant <= m_tdata[4:1];
			seen_owner <= m_tdata[9:6];
		end
	end

	// watchdog: ends the run after too many cycles with no word moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
					(cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Called at a rising edge; returns at the edge the word is taken.
	// tready is sampled at the falling edge so the handshake is race free.
	task automatic send_word(input logic [LINE_W-1:0] req,
			input logic [LINE_W-1:0] frm, input logic [LINE_W-1:0] rdy,
			input logic [DRAW_W-1:0] draw);
		int   gap;
		logic taken;
		if (burst_left > 0) begin
			gap = 0;
			burst_left--;
		end else begin
			gap = random_gap();
			if ($urandom_range(0, 32) == 0)
				burst_left = $urandom_range(20, 60);
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_DATA_W'({draw, rdy, frm, req});
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
	endtask

	// leaves cfg_valid high; the caller drops it after the last write
	task automatic write_reg(input cfg_reg_t idx, input logic [LINGER_W-1:0] val);
		logic taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
	endtask

	// hold the input side until every expected result word has come back
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending != 0);
		@(posedge clk);
	endtask

	// Bus-like activity: frame/irdy mostly follow the grantee and owner so
	// ownership actually moves; the rest is sparse or full-random noise.
	task automatic send_random();
		logic [LINE_W-1:0] req;
		logic [LINE_W-1:0] frm;
		logic [LINE_W-1:0] rdy;
		logic [DRAW_W-1:0] draw;
		int                p;
		p = $urandom_range(0, 99);
		if (p < 20)
			req = '0;
		else if (p < 50)
			req = LINE_W'(1) << $urandom_range(0, LINE_W - 1);
		else if (p < 80)
			req = LINE_W'($urandom & $urandom);
		else if (p < 95)
			req = LINE_W'($urandom);
		else
			req = '1;

		p = $urandom_range(0, 19);
		frm = (p == 0) ? LINE_W'($urandom) :
			(p < 5) ? LINE_W'($urandom & $urandom & $urandom) : '0;
		if ($urandom_range(0, 9) < 4)
			frm[seen_grant] = 1'b1;
		if ($urandom_range(0, 9) < 3)
			frm[seen_owner] = 1'b1;
		p = $urandom_range(0, 19);
		rdy = (p == 0) ? LINE_W'($urandom) :
			(p < 5) ? LINE_W'($urandom & $urandom & $urandom) : '0;
		if ($urandom_range(0, 9) < 4)
			rdy[seen_owner] = 1'b1;

		// multiples of the linger period make recall actually happen
		p = $urandom_range(0, 99);
		if (p < 30 && linger_now != 0)
			draw = DRAW_W'(linger_now * $urandom_range(0, 32'h7FFF_FFFF / linger_now));
		else if (p < 35)
			draw = '0;
		else if (p < 40)
			draw = '1;
		else
			draw = DRAW_W'($urandom);

		// now and then drain the block completely before the next word
		if ($urandom_range(0, 49) == 0) begin
			s_tvalid <= 1'b0;
			wait_drained();
		end
		send_word(req, frm, rdy, draw);
	endtask

	initial begin
		bit [0:PHASES-1]                  phase_park;
		int unsigned                      phase_linger [PHASES];
		logic [LINGER_W-1:0]              park_data;

		// settings per phase: both linger extremes, zero linger, parking
		phase_park      = 8'b1000_1010;
		phase_linger[0] = 16;
		phase_linger[1] = 1;
		phase_linger[2] = 65535;
		phase_linger[3] = 0;
		phase_linger[4] = 3;
		phase_linger[5] = $urandom_range(2, 40);
		phase_linger[6] = 2;
		phase_linger[7] = 16;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed words, reset settings (no parking, linger 16) ----
		// nothing at all
		send_word('0, '0, '0, '0);
		// single request from a random start: grant agent 3
		send_word(16'h0008, '0, '0, '0);
		// no requests, grant but no owner: recall must not happen
		send_word('0, '0, '0, '0);
		// grantee drops request, agent 0 requests: search wraps past 15
		send_word(16'h0001, '0, '0, 31'd16);
		// grantee drives frame: becomes owner
		send_word(16'h0001, 16'h0001, '0, '0);
		// highest agent requests; owner still framing
		send_word(16'h8000, 16'h0001, '0, '0);
		// owner differs from grantee, kept alive by irdy alone
		send_word(16'hFFFF, '0, 16'h0001, 31'h7FFF_FFFF);
		// owner idle: bus passes to grantee; no requests, draw multiple of 16
		send_word('0, '0, '0, 31'd32);
		// owner with no grant stays while framing
		send_word('0, 16'h8000, '0, '0);
		// owner with no grant and both lines idle: owner cleared
		send_word('0, '0, '0, '0);
		// all requests, random start from maximum draw
		send_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 31'h7FFF_FFFF);
		// grantee not requesting: odd/even agents take turns
		send_word(16'hAAAA, 16'hFFFF, 16'hFFFF, 31'h5555_5555);
		send_word(16'h5555, 16'hFFFF, 16'hFFFF, 31'h2AAA_AAAA);
		send_word(16'hAAAA, '0, '0, 31'd7);
		// no requests, draw not a multiple: grant lingers
		send_word('0, '0, '0, 31'd5);
		// no requests, draw zero: grant recalled
		send_word('0, '0, '0, '0);
		s_tvalid <= 1'b0;

		// ---- random phases, registers rewritten while idle ----
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			repeat (SETTLE_CYCLES) @(posedge clk);
			// only bit 0 of the park word counts; upper bits random
			park_data    = LINGER_W'($urandom);
			park_data[0] = phase_park[ph];
			write_reg(REG_PARK_LAST, park_data);
			write_reg(REG_LINGER_PERIOD, LINGER_W'(phase_linger[ph]));
			cfg_valid <= 1'b0;
			linger_now = phase_linger[ph];
			for (int n = 0; n < PHASE_WORDS; n++)
				send_random();
			s_tvalid <= 1'b0;
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### sim.f
hdl/brra_pkg.sv
hdl/brra_rr_pick.sv
hdl/brra_mod_unit.sv
hdl/bus_round_robin_arbiter_core.sv
bench/arbiter_grant_checker.sv
bench/bus_round_robin_arbiter_core_test.sv
